>>> design/multi_stream_saturating_mix_buffer_macros.svh
// Assertion helpers shared by the mix buffer modules.
`ifndef MULTI_STREAM_SATURATING_MIX_BUFFER_MACROS_SVH
`define MULTI_STREAM_SATURATING_MIX_BUFFER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MSMB_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msmb assertion failed");

// Next-cycle implication, checked out of reset.
`define MSMB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msmb assertion failed");

`endif

>>> design/msmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msmb_pkg;

    localparam int DEPTH_DEF   = 4096;
    localparam int FLOWS_DEF   = 16;

    localparam int SAMPLE_W    = 16;
    localparam int SLOT_W      = 4;
    localparam int FRAME_LEN_W = 13;
    localparam int LEAD_GAP_W  = 12;
    localparam int POS_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int OUTQ_DEPTH  = 3;

    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_MAX = 13'd4096;
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = 13'd960;
    localparam logic [LEAD_GAP_W-1:0]  LEAD_GAP_RST  = 12'd144;
    localparam logic                   SILENCE_RST   = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] MIX_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] MIX_MIN = 16'sh8000;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_PULL  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_LEN = 2'd0,
        CFG_LEAD_GAP  = 2'd1,
        CFG_SILENCE   = 2'd2
    } t_cfg_idx;

    // Decoded item handed from control to the store pipeline.
    typedef struct packed {
        logic                       mem_en;
        logic                       is_pull;
        logic                       zero_cur;
        logic                       frame_last;
        logic                       dropped;
        logic signed [SAMPLE_W-1:0] sample;
    } t_op;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_sample;
        logic                       sample_valid;
        logic                       frame_last;
        logic                       dropped;
    } t_result;

endpackage

`default_nettype wire

>>> design/multi_stream_saturating_mix_buffer.sv
// An accepted item passes the mix stage register and then the result queue on its way to o_m_*.
// Throughput: one item per cycle if queue has room; one read and write-back per store access.
// A 3-entry result queue takes up to three results while i_m_tready is low; intake then waits.
// Reset clears head, fill, frame position, flow offsets and active flags and
// reloads frame_len=960, lead_gap=144, silence on; store contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module multi_stream_saturating_mix_buffer import msmb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int FLOWS = FLOWS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [23:0]           i_s_tdata,   // [3:0] flow_slot, [19:4] sample_in
    input  wire logic                  i_s_tuser,   // command: 0 write, 1 pull
    // result items
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [15:0]                o_m_tdata,   // [15:0] mixed_sample
    output logic                       o_m_tlast,   // frame_last
    output logic [1:0]                 o_m_tuser,   // [0] sample_valid, [1] dropped
    // register writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(DEPTH);

    logic          accept;
    t_op           op;
    logic [AW-1:0] addr;
    logic          push;
    t_result       s1_result;
    logic          inflight;
    logic          accept_ok;
    t_result       out_result;

    // The user must write registers only while idle; the block does not enforce it, so always ready.
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = accept_ok;
    assign accept      = i_s_tvalid && accept_ok;

    // Control: flow offsets, head, fill and framing all update on accept.
    msmb_ctrl #(
        .DEPTH (DEPTH),
        .FLOWS (FLOWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_s_tuser),
        .i_slot      (i_s_tdata[SLOT_W-1:0]),
        .i_sample    (i_s_tdata[SLOT_W +: SAMPLE_W]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_op        (op),
        .o_addr      (addr)
    );

    // Store: read on accept, saturating add or clear, write back next cycle.
    msmb_mix #(
        .DEPTH (DEPTH)
    ) u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (accept),
        .i_op     (op),
        .i_addr   (addr),
        .o_push   (push),
        .o_result (s1_result),
        .o_busy   (inflight)
    );

    msmb_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (s1_result),
        .i_inflight  (inflight),
        .i_pop_ready (i_m_tready),
        .o_accept_ok (accept_ok),
        .o_valid     (o_m_tvalid),
        .o_result    (out_result)
    );

    assign o_m_tdata = out_result.mixed_sample;
    assign o_m_tlast = out_result.frame_last;
    assign o_m_tuser = {out_result.dropped, out_result.sample_valid};

endmodule

`default_nettype wire

>>> design/msmb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "multi_stream_saturating_mix_buffer_macros.svh"

module msmb_ctrl import msmb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int FLOWS = FLOWS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic                       i_command,
    input  wire logic [SLOT_W-1:0]          i_slot,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data,
    output t_op                             o_op,
    output logic [$clog2(DEPTH)-1:0]        o_addr
);

    localparam int AW      = $clog2(DEPTH);
    localparam int FW      = AW + 1;
    localparam int OFS_W   = (AW + 1 > LEAD_GAP_W) ? AW + 1 : LEAD_GAP_W;
    localparam int SLOT_IW = (FLOWS > 1) ? $clog2(FLOWS) : 1;

    logic [FRAME_LEN_W-1:0] r_frame_len;
    logic [LEAD_GAP_W-1:0]  r_lead_gap;
    logic                   r_silence;

    logic [AW-1:0]    r_head, n_head;
    logic [FW-1:0]    r_fill, n_fill;
    logic [POS_W-1:0] r_pos,  n_pos;
    logic [OFS_W-1:0] r_off [FLOWS];
    logic [OFS_W-1:0] n_off [FLOWS];
    logic             r_act [FLOWS];
    logic             n_act [FLOWS];

    logic [31:0]          slot32;
    logic [SLOT_IW-1:0]   slot_idx;
    logic                 slot_ok;
    logic [OFS_W-1:0]     lead_ext;
    logic [OFS_W-1:0]     p;
    logic [OFS_W-1:0]     p_inc;
    logic                 beyond;
    logic [AW:0]          addr_sum;
    logic [FRAME_LEN_W-1:0] flen;
    logic [FRAME_LEN_W-1:0] pos_inc;
    logic                 idle_pull;

    always_comb begin
        slot32   = 32'(i_slot);
        slot_ok  = slot32 < 32'(FLOWS);
        slot_idx = slot32[SLOT_IW-1:0];
        lead_ext = OFS_W'(r_lead_gap);
        p        = (slot_ok && r_act[slot_idx]) ? r_off[slot_idx] : lead_ext;
        p_inc    = p + 1'b1;
        beyond   = {1'b0, p} >= (OFS_W + 1)'(DEPTH);
        addr_sum = {1'b0, r_head} + {1'b0, p[AW-1:0]};
        if (addr_sum >= (AW + 1)'(DEPTH)) begin
            addr_sum = addr_sum - (AW + 1)'(DEPTH);
        end

        // zero length runs as one, anything past 4096 as 4096
        if (r_frame_len == '0) begin
            flen = FRAME_LEN_W'(1);
        end else if (r_frame_len > FRAME_LEN_MAX) begin
            flen = FRAME_LEN_MAX;
        end else begin
            flen = r_frame_len;
        end
        pos_inc   = FRAME_LEN_W'(r_pos) + 1'b1;
        idle_pull = (r_pos == '0) && (r_fill == '0) && !r_silence;

        n_head = r_head;
        n_fill = r_fill;
        n_pos  = r_pos;
        for (int i = 0; i < FLOWS; i++) begin
            n_off[i] = r_off[i];
            n_act[i] = r_act[i];
        end
        o_op        = '0;
        o_op.sample = i_sample;
        o_addr      = r_head;

        if (i_command == CMD_WRITE) begin
            if (!slot_ok) begin
                o_op.dropped = 1'b1;
            end else begin
                n_act[slot_idx] = 1'b1;
                n_off[slot_idx] = p;
                if (beyond) begin
                    o_op.dropped = 1'b1;
                end else begin
                    o_op.mem_en     = 1'b1;
                    o_op.zero_cur   = !(p < OFS_W'(r_fill));
                    o_addr          = addr_sum[AW-1:0];
                    n_off[slot_idx] = p_inc;
                    if (p_inc > OFS_W'(r_fill)) begin
                        n_fill = p_inc[FW-1:0];
                    end
                end
            end
        end else if (!idle_pull) begin
            o_op.mem_en   = 1'b1;
            o_op.is_pull  = 1'b1;
            o_op.zero_cur = (r_fill == '0);
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            if (r_fill != '0) begin
                n_fill = r_fill - 1'b1;
            end
            for (int i = 0; i < FLOWS; i++) begin
                if (r_act[i]) begin
                    n_off[i] = (r_off[i] != '0 && (r_off[i] - 1'b1) > lead_ext)
                             ? r_off[i] - 1'b1 : lead_ext;
                end
            end
            if (pos_inc >= flen) begin
                n_pos           = '0;
                o_op.frame_last = 1'b1;
            end else begin
                n_pos = pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_pos       <= '0;
            r_frame_len <= FRAME_LEN_RST;
            r_lead_gap  <= LEAD_GAP_RST;
            r_silence   <= SILENCE_RST;
            for (int i = 0; i < FLOWS; i++) begin
                r_off[i] <= '0;
                r_act[i] <= 1'b0;
            end
        end else begin
            if (i_accept) begin
                r_head <= n_head;
                r_fill <= n_fill;
                r_pos  <= n_pos;
                for (int i = 0; i < FLOWS; i++) begin
                    r_off[i] <= n_off[i];
                    r_act[i] <= n_act[i];
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_LEN: r_frame_len <= i_cfg_data;
                    CFG_LEAD_GAP:  r_lead_gap  <= i_cfg_data[LEAD_GAP_W-1:0];
                    CFG_SILENCE:   r_silence   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    `MSMB_ASSERT_NOW(a_fill_in_range, i_clk, i_rst_n, 1'b1, r_fill <= FW'(DEPTH))
    `MSMB_ASSERT_NEXT(a_pull_drains, i_clk, i_rst_n,
        i_accept && i_command == CMD_PULL && r_fill != '0, r_fill == $past(r_fill) - 1'b1)

endmodule

`default_nettype wire

>>> design/msmb_mix.sv
`timescale 1ns / 1ps
`default_nettype none

`include "multi_stream_saturating_mix_buffer_macros.svh"

module msmb_mix import msmb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_issue,
    input  wire t_op                      i_op,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    output logic                          o_push,
    output t_result                       o_result,
    output logic                          o_busy
);

    localparam int AW = $clog2(DEPTH);
    localparam logic signed [SAMPLE_W:0] SUM_HI = (SAMPLE_W + 1)'(MIX_MAX);
    localparam logic signed [SAMPLE_W:0] SUM_LO = (SAMPLE_W + 1)'(MIX_MIN);

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    logic          r_s1_valid;
    t_op           r_s1_op;
    logic [AW-1:0] r_s1_addr;

    logic                       r_wb_valid;
    logic [AW-1:0]              r_wb_addr;
    logic signed [SAMPLE_W-1:0] r_wb_data;

    logic signed [SAMPLE_W-1:0] cur;
    logic signed [SAMPLE_W:0]   sum;
    logic signed [SAMPLE_W-1:0] wr_data;
    logic                       wr_en;

    always_comb begin
        // last cycle's write-back is not yet visible in the read data
        if (r_s1_op.zero_cur) begin
            cur = '0;
        end else if (r_wb_valid && r_wb_addr == r_s1_addr) begin
            cur = r_wb_data;
        end else begin
            cur = r_rd_data;
        end
        sum = (SAMPLE_W + 1)'(cur) + (SAMPLE_W + 1)'(r_s1_op.sample);
        if (r_s1_op.is_pull) begin
            wr_data = '0;
        end else if (sum >= SUM_HI) begin
            wr_data = MIX_MAX;
        end else if (sum <= SUM_LO) begin
            wr_data = MIX_MIN;
        end else begin
            wr_data = sum[SAMPLE_W-1:0];
        end
        wr_en = r_s1_valid && r_s1_op.mem_en;

        o_result.mixed_sample = (r_s1_op.mem_en && r_s1_op.is_pull) ? cur : '0;
        o_result.sample_valid = r_s1_op.mem_en && r_s1_op.is_pull;
        o_result.frame_last   = r_s1_op.frame_last;
        o_result.dropped      = r_s1_op.dropped;
        o_push = r_s1_valid;
        o_busy = r_s1_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_issue && i_op.mem_en) begin
            r_rd_data <= r_mem[i_addr];
        end
        if (wr_en) begin
            r_mem[r_s1_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_issue;
            r_wb_valid <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_s1_op   <= i_op;
            r_s1_addr <= i_addr;
        end
        r_wb_addr <= r_s1_addr;
        r_wb_data <= wr_data;
    end

    `MSMB_ASSERT_NEXT(a_pull_clears, i_clk, i_rst_n,
        r_s1_valid && r_s1_op.mem_en && r_s1_op.is_pull, r_wb_valid && r_wb_data == '0)

endmodule

`default_nettype wire

>>> design/msmb_outq.sv
`timescale 1ns / 1ps
`default_nettype none

`include "multi_stream_saturating_mix_buffer_macros.svh"

module msmb_outq import msmb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    input  wire logic    i_inflight,
    input  wire logic    i_pop_ready,
    output logic         o_accept_ok,
    output logic         o_valid,
    output t_result      o_result
);

    localparam int PW = $clog2(OUTQ_DEPTH);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    t_result       r_q [OUTQ_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          pop;
    logic [CW:0]   claimed;

    always_comb begin
        o_valid  = r_cnt != '0;
        o_result = r_q[r_rd];
        pop      = o_valid && i_pop_ready;
        // room for the item in the mix stage plus one more
        claimed     = (CW + 1)'(r_cnt) + (CW + 1)'(i_inflight);
        o_accept_ok = claimed < (CW + 1)'(OUTQ_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(OUTQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(OUTQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_result;
        end
    end

    `MSMB_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(OUTQ_DEPTH))
    `MSMB_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n,
        i_push, r_cnt != CW'(OUTQ_DEPTH) || pop)

endmodule

`default_nettype wire
